>>> rtl/erc_pkg.sv
// ----------------------------------------------------------------------------
// erc_pkg: expo response curve shared definitions
// Constants, register map and pipeline control payload for the stick
// response curve block.
// ----------------------------------------------------------------------------
`default_nettype none

package erc_pkg;

    localparam int unsigned FULL_SCALE = 1024;  // stick full scale
    localparam int unsigned RATE_MAX   = 100;   // rate magnitude saturation
    localparam int unsigned EXT_THRESH = 80;    // fifth-power curve above this rate
    localparam int unsigned K_MAX      = 256;   // curve weight for 100 percent
    localparam int unsigned ROUND_HALF = 128;   // rounding before the final >> 8

    localparam int unsigned N_STAGES   = 7;

    // register select: paddr[2]
    localparam logic REG_EXPO_RATE     = 1'b0;
    localparam logic REG_EXTENDED_MODE = 1'b1;

    // control that travels with every request down the pipe
    typedef struct packed {
        logic        neg;     // input sign
        logic        rzero;   // pass-through
        logic        rneg;    // mirrored curve
        logic        ext;     // fifth-power term
        logic [10:0] mc;      // clamped magnitude
        logic [10:0] me;      // magnitude fed to the curve
    } t_ctl;

endpackage

`default_nettype wire

>>> rtl/expo_response_curve.sv
// ----------------------------------------------------------------------------
// expo_response_curve: expo response curve for stick samples
// Clamps a signed stick sample to +-1024 and shapes its magnitude with a
// cubic (or fifth-power) plus linear blend set by a signed percent rate.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+-------------------------------
//  stick in | in        | i_valid / o_ready | i_stick_value  (s12)
//  shaped   | out       | o_valid / i_ready | o_shaped_value (s12)
//  config   | in        | APB psel/penable  | expo_rate @0, extended_mode @4
//
//  Seven register stages: operand prep, square, scale by k, cube, two
//  fifth-power steps, sum and sign. One request per cycle unless the pipe is full and stalled.
//  The multiplier chain sets the depth; stages 1 to 5 hold the multiplies.
//  Each stage advances when it is empty or the stage after it moves, so
//  bubbles close up under a stall and the input keeps filling.
//  Synchronous active-low reset clears the valid bits and both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module expo_response_curve
    import erc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [11:0] i_stick_value,

    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [11:0]      o_shaped_value,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [7:0] r_rate;
    logic              r_ext;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= '0;
            r_ext  <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_EXPO_RATE:     r_rate <= pwdata[7:0];
                REG_EXTENDED_MODE: r_ext  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_EXPO_RATE:     prdata = 32'(r_rate);
            REG_EXTENDED_MODE: prdata = {31'd0, r_ext};
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline flow control
    // ------------------------------------------------------------------
    logic [N_STAGES-1:0] r_vld;
    logic [N_STAGES-1:0] en;

    always_comb begin
        en[N_STAGES-1] = !r_vld[N_STAGES-1] || i_ready;
        for (int i = N_STAGES - 2; i >= 0; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[N_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < N_STAGES; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 0: magnitude, rate decode, curve weight k
    // ------------------------------------------------------------------
    logic [12:0] s0_xs;
    logic [12:0] s0_mag;
    logic [10:0] s0_mc;
    logic [8:0]  s0_rs;
    logic [8:0]  s0_pa;
    logic [6:0]  s0_pc;
    logic [6:0]  s0_p2;
    logic        s0_ext;
    logic [8:0]  s0_kr;
    logic [8:0]  s0_k;
    t_ctl        s0_ctl;

    always_comb begin
        s0_xs  = {i_stick_value[11], i_stick_value};
        s0_mag = i_stick_value[11] ? 13'(-s0_xs) : s0_xs;
        s0_mc  = (s0_mag > 13'(FULL_SCALE)) ? 11'(FULL_SCALE) : s0_mag[10:0];

        s0_rs  = {r_rate[7], r_rate};
        s0_pa  = r_rate[7] ? 9'(-s0_rs) : s0_rs;
        s0_pc  = (s0_pa > 9'(RATE_MAX)) ? 7'(RATE_MAX) : s0_pa[6:0];
        s0_ext = r_ext && (s0_pc > 7'(EXT_THRESH));
        s0_p2  = s0_ext ? s0_pc : 7'(s0_pc + (s0_pc >> 2));

        // k = 2p + p/2 + p/16, 100 percent -> 256
        s0_kr  = (9'(s0_p2) << 1) + 9'(s0_p2 >> 1) + 9'(s0_p2 >> 4);
        s0_k   = (s0_kr > 9'(K_MAX)) ? 9'(K_MAX) : s0_kr;

        s0_ctl.neg   = i_stick_value[11];
        s0_ctl.rzero = (r_rate == '0);
        s0_ctl.rneg  = r_rate[7];
        s0_ctl.ext   = s0_ext;
        s0_ctl.mc    = s0_mc;
        // negative rate mirrors: curve runs on 1024 - m
        s0_ctl.me    = r_rate[7] ? 11'(FULL_SCALE) - s0_mc : s0_mc;
    end

    t_ctl        r_ctl0, r_ctl1, r_ctl2, r_ctl3, r_ctl4, r_ctl5;
    logic [8:0]  r_k0, r_k1;
    logic [20:0] r_mm1;
    logic [18:0] r_lin1, r_lin2, r_lin3, r_lin4, r_lin5;
    logic [20:0] r_t2;
    logic [30:0] r_v3;
    logic [30:0] r_w4;
    logic [30:0] r_v5;
    logic signed [11:0] r_out;

    logic [20:0] n_t2;
    logic [20:0] n_a4;
    logic [30:0] n_v5;
    logic [11:0] s6_s;
    logic [11:0] s6_y;
    logic [11:0] s6_yc;

    always_comb begin
        n_t2 = 21'((29'(r_mm1) * 29'(r_k1)) >> 8);
        n_a4 = 21'((25'(r_v3[30:16]) * 25'(r_ctl3.me)) >> 4);
        n_v5 = r_ctl4.ext ? 31'(r_w4[20:0]) * 31'(r_ctl4.me) : r_w4;

        s6_s = 12'((20'(r_v5[30:12]) + 20'(r_lin5) + 20'(ROUND_HALF)) >> 8);
        if (r_ctl5.rzero) begin
            s6_y = 12'(r_ctl5.mc);
        end else if (r_ctl5.rneg) begin
            s6_y = 12'(FULL_SCALE) - s6_s;
        end else begin
            s6_y = s6_s;
        end
        s6_yc = (s6_y > 12'(FULL_SCALE)) ? 12'(FULL_SCALE) : s6_y;
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_ctl0 <= s0_ctl;
            r_k0   <= s0_k;
        end
        // stage 1: square and linear term
        if (en[1]) begin
            r_ctl1 <= r_ctl0;
            r_k1   <= r_k0;
            r_mm1  <= 21'(r_ctl0.me) * 21'(r_ctl0.me);
            r_lin1 <= 19'(9'(K_MAX) - r_k0) * 19'(r_ctl0.me);
        end
        // stage 2: m^2 * k >> 8
        if (en[2]) begin
            r_ctl2 <= r_ctl1;
            r_lin2 <= r_lin1;
            r_t2   <= n_t2;
        end
        // stage 3: cube
        if (en[3]) begin
            r_ctl3 <= r_ctl2;
            r_lin3 <= r_lin2;
            r_v3   <= 31'(r_t2) * 31'(r_ctl2.me);
        end
        // stage 4: first fifth-power step, cube passes through otherwise
        if (en[4]) begin
            r_ctl4 <= r_ctl3;
            r_lin4 <= r_lin3;
            r_w4   <= r_ctl3.ext ? 31'(n_a4) : r_v3;
        end
        // stage 5: second fifth-power step
        if (en[5]) begin
            r_ctl5 <= r_ctl4;
            r_lin5 <= r_lin4;
            r_v5   <= n_v5;
        end
        // stage 6: blend, mirror, sign
        if (en[6]) begin
            r_out <= r_ctl5.neg ? 12'(-s6_yc) : s6_yc;
        end
    end

    assign o_shaped_value = r_out;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_shaped_value >= -12'sd1024) && (o_shaped_value <= 12'sd1024))
        else $error("shaped value beyond full scale");

    a_empty_tail_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[N_STAGES-1] |-> o_ready)
        else $error("input stalled with empty output stage");

    a_count_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !(o_valid && i_ready)) |=>
        ($countones(r_vld) == $countones($past(r_vld)) + 1))
        else $error("request lost or duplicated in pipeline");

    a_ext_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && r_ctl0.ext) |-> !r_ctl0.rzero)
        else $error("fifth-power curve flagged with zero rate");

endmodule

`default_nettype wire

>>> tb/erc_checker.sv
// ----------------------------------------------------------------------------
// erc_checker: shaped value checker for the expo response curve
// Tracks register writes on the APB port, predicts the shaped value of every
// accepted stick request and compares it with the output stream in order.
// ----------------------------------------------------------------------------
module erc_checker
    import erc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_stick_valid,
    input  logic               i_stick_ready,
    input  logic signed [11:0] i_stick_value,

    input  logic               i_shaped_valid,
    input  logic               i_shaped_ready,
    input  logic signed [11:0] i_shaped_value,

    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [2:0]         i_paddr,
    input  logic [31:0]        i_pwdata,

    output int                 o_pending,
    output int                 o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [11:0] stick;
        logic signed [11:0] shaped;
    } t_shaped_exp;

    t_shaped_exp        shaped_expected[$];
    logic signed [7:0]  rate_cfg;
    logic               ext_cfg;
    int                 fails = 0;

    // curve on a magnitude 0..1024 for a rate magnitude 0..100
    function automatic int unsigned curve_mag(int unsigned m, int unsigned pct, logic ext_on);
        logic        fifth;
        int unsigned k;
        int unsigned v;
        fifth = ext_on && (pct > EXT_THRESH);
        if (!fifth) begin
            pct = pct + (pct >> 2);
        end
        k = (pct << 1) + (pct >> 1) + (pct >> 4);
        if (k > K_MAX) begin
            k = K_MAX;
        end
        v = ((m * m * k) >> 8) * m;
        if (fifth) begin
            v = (((v >> 16) * m) >> 4) * m;
        end
        v = (v >> 12) + (K_MAX - k) * m + ROUND_HALF;
        return v >> 8;
    endfunction

    function automatic logic signed [11:0] shape_stick(logic signed [11:0] x,
                                                       logic signed [7:0] rate,
                                                       logic ext_on);
        int          xi;
        int          r;
        int          s;
        logic        neg;
        int unsigned m;
        int unsigned pct;
        int unsigned y;
        xi  = x;
        r   = rate;
        neg = xi < 0;
        m   = neg ? -xi : xi;
        if (m > FULL_SCALE) begin
            m = FULL_SCALE;
        end
        if (r == 0) begin
            y = m;
        end else if (r < 0) begin
            pct = -r;
            if (pct > RATE_MAX) pct = RATE_MAX;
            // negative rate mirrors the curve about full scale
            y = FULL_SCALE - curve_mag(FULL_SCALE - m, pct, ext_on);
        end else begin
            pct = r;
            if (pct > RATE_MAX) pct = RATE_MAX;
            y = curve_mag(m, pct, ext_on);
        end
        if (y > FULL_SCALE) begin
            y = FULL_SCALE;
        end
        s = neg ? -int'(y) : int'(y);
        return s[11:0];
    endfunction

    task automatic note_fail(string msg);
        fails++;
        if (fails <= 10) begin
            $display("erc_checker: %s", msg);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_shaped_exp want;
        t_shaped_exp req;
        if (!i_rst_n) begin
            rate_cfg = '0;
            ext_cfg  = 1'b0;
            shaped_expected.delete();
        end else begin
            if (i_shaped_valid && i_shaped_ready) begin
                if (shaped_expected.size() == 0) begin
                    note_fail($sformatf("shaped value %0d with no request pending",
                                        i_shaped_value));
                end else begin
                    want = shaped_expected.pop_front();
                    if (i_shaped_value !== want.shaped) begin
                        note_fail($sformatf("stick %0d rate %0d ext %0b: expected %0d, got %0d",
                                            want.stick, rate_cfg, ext_cfg,
                                            want.shaped, i_shaped_value));
                    end
                end
            end
            if (i_stick_valid && i_stick_ready) begin
                req.stick  = i_stick_value;
                req.shaped = shape_stick(i_stick_value, rate_cfg, ext_cfg);
                shaped_expected.push_back(req);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_EXPO_RATE) begin
                    rate_cfg = i_pwdata[7:0];
                end else begin
                    ext_cfg = i_pwdata[0];
                end
            end
        end
        o_pending    <= shaped_expected.size();
        o_fail_count <= fails;
    end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: expo response curve testbench
// Drives stick requests with and without random back-pressure across a range of rate
// and extended mode settings; erc_checker predicts and compares the output.
// ----------------------------------------------------------------------------
module tb
    import erc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          STALL_LIMIT = 2000;
    localparam logic [2:0]  ADDR_RATE   = {REG_EXPO_RATE, 2'b00};
    localparam logic [2:0]  ADDR_EXT    = {REG_EXTENDED_MODE, 2'b00};
    localparam int          N_PHASES    = 16;
    localparam int          PHASE_ITEMS = 78;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic signed [11:0] i_stick_value  = '0;
    logic               i_ready        = 1'b0;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [2:0]         paddr          = '0;
    logic [31:0]        pwdata         = '0;

    logic               o_ready;
    logic               o_valid;
    logic signed [11:0] o_shaped_value;
    logic [31:0]        prdata;
    logic               pready;

    int                 pending;
    int                 fail_count;
    int                 send_idle_pct = 6;
    int                 recv_idle_pct = 45;
    int                 quiet_cycles  = 0;

    expo_response_curve u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_stick_value  (i_stick_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_shaped_value (o_shaped_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    erc_checker u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_stick_valid  (i_valid),
        .i_stick_ready  (o_ready),
        .i_stick_value  (i_stick_value),
        .i_shaped_valid (o_valid),
        .i_shaped_ready (i_ready),
        .i_shaped_value (o_shaped_value),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // any accepted request, delivered output or APB access resets the stall count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // upper bits carry junk; only the register's own bits count
    task automatic set_curve(int rate, logic ext);
        logic [31:0] junk;
        logic [31:0] rv;
        junk = $urandom();
        rv   = rate;
        apb_write(ADDR_RATE, {junk[31:8], rv[7:0]});
        junk = $urandom();
        apb_write(ADDR_EXT, {junk[31:1], ext});
    endtask

    task automatic push_stick(logic signed [11:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_stick_value <= v;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // called at the edge of the last accepted request; the pending count
    // is registered and so lags the queue
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (N_STAGES + 2) @(posedge i_clk);
    endtask

    function automatic logic signed [11:0] rand_stick();
        int v;
        int sel;
        sel = $urandom_range(99);
        if (sel < 10) begin
            case ($urandom_range(4))
                0: v = -1024;
                1: v = 1024;
                2: v = 1;
                3: v = -1;
                default: v = 0;
            endcase
        end else if (sel < 16) begin
            v = $urandom();          // full 12-bit range, beyond full scale too
        end else begin
            v = int'($urandom_range(2048)) - 1024;
        end
        return v[11:0];
    endfunction

    initial begin : stimulus
        static logic signed [11:0] edge_vals[10] = '{0, 1, -1, 1024, -1024, 1025, -2048,
                                                     2047, 512, -700};
        static int                 phase_rate[12] = '{100, -100, 81, -81, 127, -128, 80,
                                                      -101, 50, -1, 1, 0};
        static logic               phase_ext[12]  = '{1, 1, 1, 1, 1, 0, 1, 1, 0, 1, 0, 1};
        int                 rate;
        logic               ext;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pass-through straight out of reset
        foreach (edge_vals[i]) push_stick(edge_vals[i]);
        drain();
        set_curve(127, 1'b1);
        for (int i = 0; i < 8; i++) push_stick(edge_vals[i]);
        drain();
        set_curve(-100, 1'b0);
        for (int i = 2; i < 9; i++) push_stick(edge_vals[i]);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph < 6) begin
                send_idle_pct = 6;
                recv_idle_pct = 45;
            end else if (ph < 11) begin
                send_idle_pct = 45;
                recv_idle_pct = 6;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph < 12) begin
                rate = phase_rate[ph];
                ext  = phase_ext[ph];
            end else begin
                rate = int'($urandom_range(255)) - 128;
                ext  = $urandom_range(1);
            end
            set_curve(rate, ext);
            repeat (PHASE_ITEMS) push_stick(rand_stick());
            drain();
        end

        if (fail_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
